// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/bcp_pkg.sv =====
package bcp_pkg;

   localparam int QUOT_BITS = 41;
   localparam int NUM_BITS  = 63;
   localparam int DEN_BITS  = 31;
   localparam logic [2:0] CORNER_LAST = 3'd7;

   typedef enum logic [1:0] {
      CSR_FOCAL_X  = 2'd0,
      CSR_FOCAL_Y  = 2'd1,
      CSR_CENTRE_X = 2'd2,
      CSR_CENTRE_Y = 2'd3
   } bcp_csr_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic [30:0]        size_x;
      logic [30:0]        size_y;
      logic [30:0]        size_z;
   } bcp_req_type;

   typedef struct packed {
      logic [2:0]         corner_index;
      logic               visible;
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic               last;
   } bcp_rsp_type;

   // Per-corner sideband that rides along the pipeline.
   typedef struct packed {
      logic [2:0] corner_index;
      logic       last;
      logic       visible;
   } bcp_tag_type;

endpackage

// ===== rtl/box_corner_projection.sv =====
// Oriented 3D box corner projection. Each word on req_ is one box in camera
// coordinates (Q16.16 centre, Q1.14 quaternion, Q16.16 full size); the block
// returns eight words on rsp_, one per corner in corner order 0..7, with last
// set on corner 7. A corner whose depth is not positive comes out with visible
// low and zero pixel fields. Rate: one corner per cycle while rsp_ is not
// stalled, set by the corner expander feeding the pipeline, which takes a new
// box as the last corner of the current one issues. Steps to rsp_: the
// expander issues corner 0 straight from its box register, then come five
// transform stages (quaternion products, matrix, products, row sums,
// translate), two projection set-up stages, 42 stages of a one-bit-per-stage
// divider for u and v, a sign/limit stage and the output register. The whole
// pipeline holds while a result sits unread on rsp_.
// Write focal_x, focal_y, centre_x, centre_y (indexes 0..3) only while idle.
module box_corner_projection
   import bcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bcp_req_type req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bcp_rsp_type rsp,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

`include "assert_macros.svh"

   localparam logic [QUOT_BITS-1:0] QUOT_LIMIT = QUOT_BITS'(1) << (QUOT_BITS - 1);
   localparam logic signed [43:0]   I32_MAX    = 44'sd2147483647;
   localparam logic signed [43:0]   I32_MIN    = -44'sd2147483648;

   // configuration registers
   logic [31:0] focal_x_ff, focal_y_ff, centre_x_ff, centre_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 32'd0;
         focal_y_ff  <= 32'd0;
         centre_x_ff <= 32'd0;
         centre_y_ff <= 32'd0;
      end else if (csr_wr_en) begin
         case (bcp_csr_type'(csr_index))
            CSR_FOCAL_X:  focal_x_ff  <= csr_wr_data;
            CSR_FOCAL_Y:  focal_y_ff  <= csr_wr_data;
            CSR_CENTRE_X: centre_x_ff <= csr_wr_data;
            CSR_CENTRE_Y: centre_y_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // advance every stage when the output register is free or being drained
   logic        rsp_valid_ff;
   bcp_rsp_type rsp_ff;
   logic        adv;

   assign adv = !rsp_valid_ff || rsp_ready;

   // corner expander: hold one box, issue its corners one per cycle while not stalled
   logic        cor_valid;
   logic [2:0]  cor_index;
   logic        cor_last;
   bcp_req_type cor_box;

   bcp_expander u_expander (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req          (req),
      .corner_valid (cor_valid),
      .corner_index (cor_index),
      .corner_last  (cor_last),
      .box          (cor_box)
   );

   // rotate, offset and translate each corner
   logic               xf_valid;
   bcp_tag_type        xf_tag;
   logic signed [31:0] xf_x, xf_y, xf_z;

   bcp_transform u_transform (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cor_valid),
      .in_index  (cor_index),
      .in_last   (cor_last),
      .box       (cor_box),
      .out_valid (xf_valid),
      .out_tag   (xf_tag),
      .c_x       (xf_x),
      .c_y       (xf_y),
      .c_z       (xf_z)
   );

   // projection set-up: focal * coordinate, then magnitude and sign
   logic                v6_ff, v7_ff;
   bcp_tag_type         tag6_ff, tag7_ff;
   logic signed [63:0]  prod6_ff [2];
   logic [DEN_BITS-1:0] den6_ff, den7_ff;
   logic [NUM_BITS-1:0] num7_ff [2];
   logic                neg7_ff [2];
   logic signed [64:0]  prod_in [2];
   logic signed [63:0]  mag_in [2];

   always_comb begin
      prod_in[0] = $signed({1'b0, focal_x_ff}) * xf_x;
      prod_in[1] = $signed({1'b0, focal_y_ff}) * xf_y;
      for (int l = 0; l < 2; l++) begin
         mag_in[l] = prod6_ff[l][63] ? -prod6_ff[l] : prod6_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= xf_valid;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag6_ff <= xf_tag;
         // hidden corners divide by one; their pixels are dropped later
         den6_ff <= xf_tag.visible ? xf_z[DEN_BITS-1:0] : DEN_BITS'(1);
         tag7_ff <= tag6_ff;
         den7_ff <= den6_ff;
         for (int l = 0; l < 2; l++) begin
            prod6_ff[l] <= prod_in[l][63:0];
            num7_ff[l]  <= mag_in[l][NUM_BITS-1:0];
            neg7_ff[l]  <= prod6_ff[l][63];
         end
      end
   end

   // truncating divide of both lanes by depth
   logic                 dv_valid;
   bcp_tag_type          dv_tag;
   logic [QUOT_BITS-1:0] dv_quot [2];
   logic                 dv_neg [2];
   logic                 dv_ovf [2];

   bcp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v7_ff),
      .in_tag    (tag7_ff),
      .in_num    (num7_ff),
      .in_neg    (neg7_ff),
      .in_den    (den7_ff),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_quot  (dv_quot),
      .out_neg   (dv_neg),
      .out_ovf   (dv_ovf)
   );

   // limit the quotient to +-2^40 and restore its sign
   logic                 vq_ff;
   bcp_tag_type          tagq_ff;
   logic signed [QUOT_BITS:0] sq_ff [2];
   logic [QUOT_BITS-1:0] lim_q [2];
   logic signed [QUOT_BITS:0] sq_in [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         lim_q[l] = (dv_ovf[l] || dv_quot[l] > QUOT_LIMIT) ? QUOT_LIMIT : dv_quot[l];
         sq_in[l] = dv_neg[l] ? -$signed({1'b0, lim_q[l]}) : $signed({1'b0, lim_q[l]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff <= 1'b0;
      end else if (adv) begin
         vq_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tagq_ff <= dv_tag;
         for (int l = 0; l < 2; l++) begin
            sq_ff[l] <= sq_in[l];
         end
      end
   end

   // add principal point, saturate, drop pixels of hidden corners
   logic signed [43:0] pix_sum [2];
   logic signed [31:0] pix_sat [2];
   bcp_rsp_type        rsp_in;

   always_comb begin
      pix_sum[0] = 44'(sq_ff[0]) + $signed({12'd0, centre_x_ff});
      pix_sum[1] = 44'(sq_ff[1]) + $signed({12'd0, centre_y_ff});
      for (int l = 0; l < 2; l++) begin
         if (pix_sum[l] > I32_MAX) begin
            pix_sat[l] = 32'sh7FFFFFFF;
         end else if (pix_sum[l] < I32_MIN) begin
            pix_sat[l] = 32'sh80000000;
         end else begin
            pix_sat[l] = pix_sum[l][31:0];
         end
      end
      rsp_in.corner_index = tagq_ff.corner_index;
      rsp_in.visible      = tagq_ff.visible;
      rsp_in.last         = tagq_ff.last;
      rsp_in.pixel_u      = tagq_ff.visible ? pix_sat[0] : 32'sd0;
      rsp_in.pixel_v      = tagq_ff.visible ? pix_sat[1] : 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // last marks corner 7 and nothing else
   `ASSERT_IMPLIES(a_last_is_corner7, clock, reset, rsp_valid_ff, (rsp_ff.last == (rsp_ff.corner_index == CORNER_LAST)), "last flag does not match corner 7")
   // hidden corners carry zero pixels
   `ASSERT_IMPLIES(a_hidden_zero, clock, reset, rsp_valid_ff && !rsp_ff.visible, rsp_ff.pixel_u == 32'sd0 && rsp_ff.pixel_v == 32'sd0, "hidden corner with pixel data")
   // a box is only taken once the previous box issues its final corner
   `ASSERT_IMPLIES(a_box_after_last, clock, reset, req_valid && req_ready && cor_valid, cor_last, "box accepted mid-box")
   // a stall freezes the corner issue point
   `ASSERT_NEXT(a_stall_holds_issue, clock, reset, !adv && cor_valid, cor_valid && $stable(cor_index), "corner issue moved during stall")

endmodule

// ===== rtl/bcp_expander.sv =====
module bcp_expander
   import bcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        req_valid,
   output logic        req_ready,
   input  bcp_req_type req,
   output logic        corner_valid,
   output logic [2:0]  corner_index,
   output logic        corner_last,
   output bcp_req_type box
);

   logic        busy_ff, busy_in;
   logic [2:0]  cnt_ff, cnt_in;
   bcp_req_type box_ff;
   logic        take;

   // take a new box when idle or while the last corner of the current one leaves
   assign req_ready = adv && (!busy_ff || cnt_ff == CORNER_LAST);
   assign take      = req_valid && req_ready;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (adv && busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == CORNER_LAST) begin
            busy_in = 1'b0;
         end
      end
      if (take) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         box_ff <= req;
      end
   end

   assign corner_valid = busy_ff;
   assign corner_index = cnt_ff;
   assign corner_last  = (cnt_ff == CORNER_LAST);
   assign box          = box_ff;

endmodule

// ===== rtl/bcp_transform.sv =====
module bcp_transform
   import bcp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [2:0]         in_index,
   input  logic               in_last,
   input  bcp_req_type        box,
   output logic               out_valid,
   output bcp_tag_type        out_tag,
   output logic signed [31:0] c_x,
   output logic signed [31:0] c_y,
   output logic signed [31:0] c_z
);

   localparam logic signed [35:0] ONE_Q28   = 36'sh010000000;
   localparam logic signed [35:0] HALF_Q8   = 36'sd128;
   localparam logic signed [63:0] HALF_Q21  = 64'sd1048576;
   localparam logic signed [43:0] I32_MAX   = 44'sd2147483647;
   localparam logic signed [43:0] I32_MIN   = -44'sd2147483648;

   // stage 1: quaternion products and corner offsets
   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [2:0]         idx1_ff, idx2_ff, idx3_ff, idx4_ff, idx5_ff;
   logic               last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic signed [31:0] qp1_ff [9];
   logic signed [31:0] qp_in [9];
   logic signed [31:0] off_in [3];
   logic signed [31:0] off1_ff [3];
   logic signed [31:0] off2_ff [3];
   logic signed [31:0] pos1_ff [3];
   logic signed [31:0] pos2_ff [3];
   logic signed [31:0] pos3_ff [3];
   logic signed [31:0] pos4_ff [3];
   // stage 2: rotation matrix, Q.20
   logic signed [35:0] m_full [9];
   logic signed [35:0] m_rnd [9];
   logic signed [27:0] rm2_ff [9];
   // stage 3: matrix times offset
   logic signed [59:0] p3_ff [9];
   // stage 4: row sums rounded to Q.16
   logic signed [63:0] s_sum [3];
   logic signed [63:0] s_rnd [3];
   logic signed [42:0] rs4_ff [3];
   // stage 5: translate and saturate
   logic signed [43:0] t_sum [3];
   logic signed [31:0] c_in [3];
   logic signed [31:0] c5_ff [3];
   logic               vis_in, vis5_ff;

   // products: xx yy zz xy xz yz wx wy wz
   always_comb begin
      qp_in[0] = box.quat_x * box.quat_x;
      qp_in[1] = box.quat_y * box.quat_y;
      qp_in[2] = box.quat_z * box.quat_z;
      qp_in[3] = box.quat_x * box.quat_y;
      qp_in[4] = box.quat_x * box.quat_z;
      qp_in[5] = box.quat_y * box.quat_z;
      qp_in[6] = box.quat_w * box.quat_x;
      qp_in[7] = box.quat_w * box.quat_y;
      qp_in[8] = box.quat_w * box.quat_z;
      off_in[0] = in_index[2] ? -$signed({1'b0, box.size_x}) : $signed({1'b0, box.size_x});
      off_in[1] = in_index[1] ? -$signed({1'b0, box.size_y}) : $signed({1'b0, box.size_y});
      off_in[2] = in_index[0] ? -$signed({1'b0, box.size_z}) : $signed({1'b0, box.size_z});
   end

   always_comb begin
      m_full[0] = ONE_Q28 - ((36'(qp1_ff[1]) + 36'(qp1_ff[2])) <<< 1);
      m_full[1] = (36'(qp1_ff[3]) - 36'(qp1_ff[8])) <<< 1;
      m_full[2] = (36'(qp1_ff[4]) + 36'(qp1_ff[7])) <<< 1;
      m_full[3] = (36'(qp1_ff[3]) + 36'(qp1_ff[8])) <<< 1;
      m_full[4] = ONE_Q28 - ((36'(qp1_ff[0]) + 36'(qp1_ff[2])) <<< 1);
      m_full[5] = (36'(qp1_ff[5]) - 36'(qp1_ff[6])) <<< 1;
      m_full[6] = (36'(qp1_ff[4]) - 36'(qp1_ff[7])) <<< 1;
      m_full[7] = (36'(qp1_ff[5]) + 36'(qp1_ff[6])) <<< 1;
      m_full[8] = ONE_Q28 - ((36'(qp1_ff[0]) + 36'(qp1_ff[1])) <<< 1);
      for (int i = 0; i < 9; i++) begin
         m_rnd[i] = (m_full[i] + HALF_Q8) >>> 8;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s_sum[r] = 64'(p3_ff[3*r]) + 64'(p3_ff[3*r+1]) + 64'(p3_ff[3*r+2]);
         s_rnd[r] = (s_sum[r] + HALF_Q21) >>> 21;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         t_sum[r] = 44'(rs4_ff[r]) + 44'(pos4_ff[r]);
         if (t_sum[r] > I32_MAX) begin
            c_in[r] = 32'sh7FFFFFFF;
         end else if (t_sum[r] < I32_MIN) begin
            c_in[r] = 32'sh80000000;
         end else begin
            c_in[r] = t_sum[r][31:0];
         end
      end
      vis_in = (c_in[2] > 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx1_ff  <= in_index;
         last1_ff <= in_last;
         idx2_ff  <= idx1_ff;
         last2_ff <= last1_ff;
         idx3_ff  <= idx2_ff;
         last3_ff <= last2_ff;
         idx4_ff  <= idx3_ff;
         last4_ff <= last3_ff;
         idx5_ff  <= idx4_ff;
         last5_ff <= last4_ff;
         vis5_ff  <= vis_in;
         for (int i = 0; i < 9; i++) begin
            qp1_ff[i] <= qp_in[i];
            rm2_ff[i] <= m_rnd[i][27:0];
         end
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               p3_ff[3*r+c] <= rm2_ff[3*r+c] * off2_ff[c];
            end
            off1_ff[r] <= off_in[r];
            off2_ff[r] <= off1_ff[r];
            rs4_ff[r]  <= s_rnd[r][42:0];
            c5_ff[r]   <= c_in[r];
         end
         pos1_ff[0] <= box.pos_x;
         pos1_ff[1] <= box.pos_y;
         pos1_ff[2] <= box.pos_z;
         for (int r = 0; r < 3; r++) begin
            pos2_ff[r] <= pos1_ff[r];
            pos3_ff[r] <= pos2_ff[r];
            pos4_ff[r] <= pos3_ff[r];
         end
      end
   end

   assign out_valid            = v5_ff;
   assign out_tag.corner_index = idx5_ff;
   assign out_tag.last         = last5_ff;
   assign out_tag.visible      = vis5_ff;
   assign c_x                  = c5_ff[0];
   assign c_y                  = c5_ff[1];
   assign c_z                  = c5_ff[2];

endmodule

// ===== rtl/bcp_divider.sv =====
module bcp_divider
   import bcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  bcp_tag_type          in_tag,
   input  logic [NUM_BITS-1:0]  in_num [2],
   input  logic                 in_neg [2],
   input  logic [DEN_BITS-1:0]  in_den,
   output logic                 out_valid,
   output bcp_tag_type          out_tag,
   output logic [QUOT_BITS-1:0] out_quot [2],
   output logic                 out_neg [2],
   output logic                 out_ovf [2]
);

   localparam int STAGES = QUOT_BITS + 1;
   localparam int HI_BITS = NUM_BITS - QUOT_BITS;

   // one quotient bit per stage after the first; sh holds remaining dividend bits
   // shifting out on top and quotient bits shifting in below
   logic                 valid_ff [STAGES];
   bcp_tag_type          tag_ff   [STAGES];
   logic [DEN_BITS-1:0]  den_ff   [STAGES];
   logic [DEN_BITS-1:0]  rem_ff   [STAGES][2];
   logic [QUOT_BITS-1:0] sh_ff    [STAGES][2];
   logic                 neg_ff   [STAGES][2];
   logic                 ovf_ff   [STAGES][2];
   logic [DEN_BITS:0]    trial    [STAGES][2];
   logic                 ge       [STAGES][2];
   logic [DEN_BITS-1:0]  hi_in    [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         hi_in[l] = DEN_BITS'(in_num[l][NUM_BITS-1:QUOT_BITS]);
      end
      for (int s = 0; s < STAGES; s++) begin
         for (int l = 0; l < 2; l++) begin
            trial[s][l] = {rem_ff[s][l], sh_ff[s][l][QUOT_BITS-1]};
            ge[s][l]    = trial[s][l] >= {1'b0, den_ff[s]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= in_tag;
         den_ff[0] <= in_den;
         for (int l = 0; l < 2; l++) begin
            rem_ff[0][l] <= hi_in[l];
            sh_ff[0][l]  <= in_num[l][QUOT_BITS-1:0];
            neg_ff[0][l] <= in_neg[l];
            // quotient would need more than QUOT_BITS bits
            ovf_ff[0][l] <= (hi_in[l] >= in_den) && (HI_BITS > 0);
         end
         for (int s = 1; s < STAGES; s++) begin
            tag_ff[s] <= tag_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            for (int l = 0; l < 2; l++) begin
               rem_ff[s][l] <= ge[s-1][l]
                  ? DEN_BITS'(trial[s-1][l] - {1'b0, den_ff[s-1]})
                  : trial[s-1][l][DEN_BITS-1:0];
               sh_ff[s][l]  <= {sh_ff[s-1][l][QUOT_BITS-2:0], ge[s-1][l]};
               neg_ff[s][l] <= neg_ff[s-1][l];
               ovf_ff[s][l] <= ovf_ff[s-1][l];
            end
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         out_quot[l] = sh_ff[STAGES-1][l];
         out_neg[l]  = neg_ff[STAGES-1][l];
         out_ovf[l]  = ovf_ff[STAGES-1][l];
      end
   end

endmodule
